@@ hdl/assert_macros.svh @@
// Concurrent assertion helpers; they sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: name");
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: name");
`else
`define ASSERT_IMPLY(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ hdl/unio_pkg.sv @@
package unio_pkg;

    localparam int TIMER_WIDTH = 16;

    localparam int QBIT_WIDTH = 10;
    localparam int REG_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH = 2;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 16;

    localparam logic [7:0] HEADER_BYTE = 8'h55;

    localparam logic [QBIT_WIDTH-1:0] QBIT_RESET    = 10'd10;
    localparam logic [REG_WIDTH-1:0]  SB_HIGH_RESET = 16'd605;
    localparam logic [REG_WIDTH-1:0]  SETUP_RESET   = 16'd15;
    localparam logic [REG_WIDTH-1:0]  HDR_LOW_RESET = 16'd10;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_QUARTER_BIT  = 2'd0,
        CFG_STANDBY_HIGH = 2'd1,
        CFG_SETUP        = 2'd2,
        CFG_HEADER_LOW   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_STANDBY = 3'd1,
        CMD_GAP     = 3'd2,
        CMD_HEADER  = 3'd3,
        CMD_SEND    = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_SB_LOW    = 8'b0000_0010,
        PH_SB_HIGH   = 8'b0000_0100,
        PH_GAP       = 8'b0000_1000,
        PH_HDR_LOW   = 8'b0001_0000,
        PH_HDR_BITS  = 8'b0010_0000,
        PH_SEND_BITS = 8'b0100_0000,
        PH_READ_BITS = 8'b1000_0000
    } phase_t;

    localparam logic [3:0] BIT_MAK = 4'd8;
    localparam logic [3:0] BIT_LAST_DATA = 4'd7;

    // Duration register to timer value, saturated at the timer range.
    function automatic logic [TIMER_WIDTH-1:0] sat_dur(input logic [REG_WIDTH-1:0] v);
        logic [TIMER_WIDTH+REG_WIDTH-1:0] wide;
        logic [TIMER_WIDTH+REG_WIDTH-1:0] lim;
        wide = {{TIMER_WIDTH{1'b0}}, v};
        lim  = {{REG_WIDTH{1'b0}}, {TIMER_WIDTH{1'b1}}};
        if (wide > lim)
            return {TIMER_WIDTH{1'b1}};
        else
            return wide[TIMER_WIDTH-1:0];
    endfunction

endpackage

@@ hdl/unio_bus_master_engine.sv @@
// UNI/O single-wire bus master. Every input transaction is one timebase tick carrying
// an optional command, a transmit byte, the MAK flag and the sampled bus pin; every
// input transaction yields exactly one output transaction with the bus level, the
// drive enable, busy/done flags, the last received byte and the SAK result. The whole
// tick is worked out combinationally and its result is loaded into the output register at
// the accepting edge, visible from the next cycle. A new tick is taken whenever that
// register is empty or its result leaves in the same cycle, so ticks can follow back to
// back; a result that waits stalls the input. Durations are counted in ticks, so a
// stalled stream stretches bus timing. Config writes belong between commands, while the
// engine is idle.
`include "assert_macros.svh"

module unio_bus_master_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cmd[2:0], tx_byte[10:3], mak[11], bus_in[12], zero[15:13]
    input  logic [unio_pkg::IN_WIDTH-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // bus_out[0], bus_drive[1], busy_res[2], done_res[3], rx_byte[11:4], ack_ok[12],
    // zero[15:13]
    output logic [unio_pkg::OUT_WIDTH-1:0]       m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [unio_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [unio_pkg::REG_WIDTH-1:0]       cfg_wdata
);
    import unio_pkg::*;

    logic [QBIT_WIDTH-1:0] quarter_bit_ticks_reg;
    logic [REG_WIDTH-1:0]  standby_high_ticks_reg;
    logic [REG_WIDTH-1:0]  setup_ticks_reg;
    logic [REG_WIDTH-1:0]  header_low_ticks_reg;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic [1:0]             quarter_reg, quarter_next;
    logic [3:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   first_sample_reg, first_sample_next;
    logic                   mak_hold_reg, mak_hold_next;
    logic                   sak_reg, sak_next;
    logic [7:0]             rx_reg, rx_next;

    logic                   out_valid_reg;
    logic [OUT_WIDTH-1:0]   out_data_reg;

    logic [2:0] in_cmd;
    logic [7:0] in_tx_byte;
    logic       in_mak;
    logic       in_bus;

    logic                   accept;
    logic                   level, drive, busy, done;
    logic [TIMER_WIDTH-1:0] dur;
    logic [TIMER_WIDTH:0]   tick_inc;
    logic                   last;
    logic                   rd;
    logic                   w;
    logic                   bv;

    assign in_cmd     = s_axis_tdata[2:0];
    assign in_tx_byte = s_axis_tdata[10:3];
    assign in_mak     = s_axis_tdata[11];
    assign in_bus     = s_axis_tdata[12];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_bit_ticks_reg  <= QBIT_RESET;
            standby_high_ticks_reg <= SB_HIGH_RESET;
            setup_ticks_reg        <= SETUP_RESET;
            header_low_ticks_reg   <= HDR_LOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_QUARTER_BIT:  quarter_bit_ticks_reg  <= cfg_wdata[QBIT_WIDTH-1:0];
                CFG_STANDBY_HIGH: standby_high_ticks_reg <= cfg_wdata;
                CFG_SETUP:        setup_ticks_reg        <= cfg_wdata;
                CFG_HEADER_LOW:   header_low_ticks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        tick_next         = tick_reg;
        quarter_next      = quarter_reg;
        bit_next          = bit_reg;
        shift_next        = shift_reg;
        first_sample_next = first_sample_reg;
        mak_hold_next     = mak_hold_reg;
        sak_next          = sak_reg;
        rx_next           = rx_reg;
        level = 1'b1;
        drive = 1'b1;
        busy  = 1'b0;
        done  = 1'b0;
        dur   = '0;
        tick_inc = '0;
        last  = 1'b0;
        rd    = 1'b0;
        w     = 1'b1;
        bv    = 1'b0;

        // Command launch; the launch tick is already the first tick of the command.
        if (phase_reg == PH_IDLE)
        begin
            unique case (cmd_t'(in_cmd))
                CMD_STANDBY:
                begin
                    phase_next = PH_SB_LOW;
                    sak_next   = 1'b1;
                end
                CMD_GAP:
                begin
                    phase_next = PH_GAP;
                    sak_next   = 1'b1;
                end
                CMD_HEADER:
                begin
                    phase_next    = PH_HDR_LOW;
                    sak_next      = 1'b1;
                    shift_next    = HEADER_BYTE;
                    mak_hold_next = 1'b1;
                end
                CMD_SEND:
                begin
                    phase_next    = PH_SEND_BITS;
                    shift_next    = in_tx_byte;
                    mak_hold_next = in_mak;
                end
                CMD_READ:
                begin
                    phase_next    = PH_READ_BITS;
                    shift_next    = '0;
                    mak_hold_next = in_mak;
                end
                default: ;
            endcase
            if (phase_next != PH_IDLE)
            begin
                tick_next    = '0;
                quarter_next = '0;
                bit_next     = '0;
            end
        end

        if (phase_next != PH_IDLE)
        begin
            busy = 1'b1;
            rd   = (phase_next == PH_READ_BITS);
            unique case (phase_next)
                PH_SB_LOW:
                begin
                    dur   = sat_dur(setup_ticks_reg);
                    level = 1'b0;
                end
                PH_SB_HIGH: dur = sat_dur(standby_high_ticks_reg);
                PH_GAP:     dur = sat_dur(setup_ticks_reg);
                PH_HDR_LOW:
                begin
                    dur   = sat_dur(header_low_ticks_reg);
                    level = 1'b0;
                end
                PH_HDR_BITS, PH_SEND_BITS, PH_READ_BITS:
                begin
                    dur = sat_dur({{(REG_WIDTH-QBIT_WIDTH){1'b0}}, quarter_bit_ticks_reg});
                    if (bit_next < BIT_MAK)
                        w = rd ? 1'b1 : shift_next[7];
                    else if (bit_next == BIT_MAK)
                        w = mak_hold_next;
                    else
                        w = 1'b1;
                    level = quarter_next[1] ? w : ~w;
                    if (bit_next > BIT_MAK || (rd && bit_next < BIT_MAK))
                    begin
                        drive = 1'b0;
                        level = 1'b1;
                    end
                end
                default: ;
            endcase

            tick_inc = {1'b0, tick_next} + {{TIMER_WIDTH{1'b0}}, 1'b1};
            last     = (tick_inc >= {1'b0, dur});
            if (!last)
            begin
                tick_next = tick_inc[TIMER_WIDTH-1:0];
            end
            else
            begin
                tick_next = '0;
                priority case (phase_next)
                    PH_SB_LOW: phase_next = PH_SB_HIGH;
                    PH_SB_HIGH, PH_GAP:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_HDR_LOW:
                    begin
                        phase_next   = PH_HDR_BITS;
                        quarter_next = '0;
                        bit_next     = '0;
                    end
                    default:
                    begin
                        if (quarter_next == 2'd0)
                            first_sample_next = in_bus;
                        if (quarter_next == 2'd2)
                        begin
                            bv = in_bus && !first_sample_next;
                            if (rd && bit_next < BIT_MAK)
                            begin
                                shift_next = {shift_next[6:0], bv};
                                if (bit_next == BIT_LAST_DATA)
                                    rx_next = shift_next;
                            end
                            if (bit_next > BIT_MAK && phase_next != PH_HDR_BITS)
                                sak_next = bv;
                        end
                        if (quarter_next == 2'd3)
                        begin
                            if (!rd && bit_next < BIT_MAK)
                                shift_next = {shift_next[6:0], 1'b0};
                            if (bit_next > BIT_MAK)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_next = bit_next + 4'd1;
                            end
                        end
                        quarter_next = quarter_next + 2'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_reg         <= '0;
            quarter_reg      <= '0;
            bit_reg          <= '0;
            shift_reg        <= '0;
            first_sample_reg <= 1'b0;
            mak_hold_reg     <= 1'b0;
            sak_reg          <= 1'b0;
            rx_reg           <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            tick_reg         <= tick_next;
            quarter_reg      <= quarter_next;
            bit_reg          <= bit_next;
            shift_reg        <= shift_next;
            first_sample_reg <= first_sample_next;
            mak_hold_reg     <= mak_hold_next;
            sak_reg          <= sak_next;
            rx_reg           <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {3'b000, sak_next, rx_next, done, busy, drive, level};
    end

    `ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg)
    `ASSERT_NEXT(a_done_returns_idle, accept && done, phase_reg == PH_IDLE)
    `ASSERT_IMPLY(a_idle_timer_clear, phase_reg == PH_IDLE, tick_reg == '0)
    `ASSERT_IMPLY(a_bit_index_range, phase_reg != PH_IDLE, bit_reg <= (BIT_MAK + 4'd1))
    `ASSERT_IMPLY(a_released_reads_high, out_valid_reg && !out_data_reg[1], out_data_reg[0])

endmodule

@@ bench/unio_bus_master_engine_tb.sv @@
module unio_bus_master_engine_tb;

    import unio_pkg::*;

    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam logic [3:0] BIT_SAK = 4'd9;
    localparam int TIMEOUT_CYCLES = 50000;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic       bus_out;
        logic       bus_drive;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_ok;
    } bus_state_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // cmd[2:0], tx_byte[10:3], mak[11], bus_in[12], zero[15:13]
    logic [IN_WIDTH-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // bus_out[0], bus_drive[1], busy_res[2], done_res[3], rx_byte[11:4], ack_ok[12], zero[15:13]
    logic [OUT_WIDTH-1:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0] cfg_wdata = '0;

    // engine model state
    phase_t eng_phase;
    logic [15:0] eng_ticks;
    logic [1:0] eng_quarter;
    logic [3:0] eng_bit;
    logic [7:0] eng_shift;
    logic eng_first;
    logic eng_mak;
    logic eng_sak;
    logic [7:0] eng_rx;

    logic [QBIT_WIDTH-1:0] cfg_qbit;
    logic [REG_WIDTH-1:0] cfg_sb_high;
    logic [REG_WIDTH-1:0] cfg_setup;
    logic [REG_WIDTH-1:0] cfg_hdr_low;

    bus_state_t pending_bus_states[$];

    // slave behavior on the line
    logic [7:0] slave_byte = 8'h00;
    logic slave_sak = 1'b1;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    int error_count = 0;
    int tick_total = 0;
    int cmd_total = 0;

    unio_bus_master_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR %0d: %s", error_count, msg);
    endtask

    function automatic logic [15:0] eff_ticks(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic bus_state_t predict_bus_state(input logic [2:0] cmd, input logic [7:0] txb,
                                                     input logic mk, input logic bin);
        bus_state_t r;
        logic [15:0] dur;
        logic w;
        logic rd;
        logic lastt;
        logic bv;
        r.bus_out = 1'b1;
        r.bus_drive = 1'b1;
        r.busy = 1'b0;
        r.done = 1'b0;
        if (eng_phase == PH_IDLE && cmd >= CMD_STANDBY && cmd <= CMD_READ)
        begin
            eng_ticks = '0;
            eng_quarter = '0;
            eng_bit = '0;
            case (cmd)
                CMD_STANDBY:
                begin
                    eng_phase = PH_SB_LOW;
                    eng_sak = 1'b1;
                end
                CMD_GAP:
                begin
                    eng_phase = PH_GAP;
                    eng_sak = 1'b1;
                end
                CMD_HEADER:
                begin
                    eng_phase = PH_HDR_LOW;
                    eng_sak = 1'b1;
                    eng_shift = HEADER_BYTE;
                    eng_mak = 1'b1;
                end
                CMD_SEND:
                begin
                    eng_phase = PH_SEND_BITS;
                    eng_shift = txb;
                    eng_mak = mk;
                end
                default:
                begin
                    eng_phase = PH_READ_BITS;
                    eng_shift = 8'h00;
                    eng_mak = mk;
                end
            endcase
        end
        if (eng_phase != PH_IDLE)
        begin
            r.busy = 1'b1;
            rd = (eng_phase == PH_READ_BITS);
            case (eng_phase)
                PH_SB_LOW:
                begin
                    dur = eff_ticks(cfg_setup);
                    r.bus_out = 1'b0;
                end
                PH_SB_HIGH: dur = eff_ticks(cfg_sb_high);
                PH_GAP: dur = eff_ticks(cfg_setup);
                PH_HDR_LOW:
                begin
                    dur = eff_ticks(cfg_hdr_low);
                    r.bus_out = 1'b0;
                end
                default:
                begin
                    dur = eff_ticks({6'd0, cfg_qbit});
                    if (eng_bit < BIT_MAK)
                        w = rd ? 1'b1 : eng_shift[7];
                    else if (eng_bit == BIT_MAK)
                        w = eng_mak;
                    else
                        w = 1'b1;
                    r.bus_out = (eng_quarter < 2'd2) ? ~w : w;
                    if (eng_bit >= BIT_SAK || (rd && eng_bit < BIT_MAK))
                    begin
                        r.bus_drive = 1'b0;
                        r.bus_out = 1'b1;
                    end
                end
            endcase
            lastt = ({1'b0, eng_ticks} + 17'd1) >= {1'b0, dur};
            if (!lastt)
                eng_ticks = eng_ticks + 16'd1;
            else
            begin
                eng_ticks = '0;
                case (eng_phase)
                    PH_SB_LOW: eng_phase = PH_SB_HIGH;
                    PH_SB_HIGH, PH_GAP:
                    begin
                        eng_phase = PH_IDLE;
                        r.done = 1'b1;
                    end
                    PH_HDR_LOW:
                    begin
                        eng_phase = PH_HDR_BITS;
                        eng_quarter = '0;
                        eng_bit = '0;
                    end
                    default:
                    begin
                        if (eng_quarter == 2'd0)
                            eng_first = bin;
                        if (eng_quarter == 2'd2)
                        begin
                            bv = bin & ~eng_first;
                            if (rd && eng_bit < BIT_MAK)
                            begin
                                eng_shift = {eng_shift[6:0], bv};
                                if (eng_bit == BIT_LAST_DATA)
                                    eng_rx = eng_shift;
                            end
                            if (eng_bit >= BIT_SAK && eng_phase != PH_HDR_BITS)
                                eng_sak = bv;
                        end
                        if (eng_quarter == 2'd3)
                        begin
                            if (!rd && eng_bit < BIT_MAK)
                                eng_shift = {eng_shift[6:0], 1'b0};
                            if (eng_bit >= BIT_SAK)
                            begin
                                eng_phase = PH_IDLE;
                                r.done = 1'b1;
                            end
                            else
                                eng_bit = eng_bit + 4'd1;
                        end
                        eng_quarter = eng_quarter + 2'd1;
                    end
                endcase
            end
        end
        r.rx_byte = eng_rx;
        r.ack_ok = eng_sak;
        return r;
    endfunction

    // level a well-behaved slave would leave on the pin for the coming tick
    function automatic logic slave_level(input logic [2:0] cmd, input int noise_pct);
        phase_t p;
        logic [1:0] q;
        logic [3:0] b;
        logic v;
        p = eng_phase;
        q = eng_quarter;
        b = eng_bit;
        if (p == PH_IDLE && cmd == CMD_READ)
        begin
            p = PH_READ_BITS;
            q = 2'd0;
            b = 4'd0;
        end
        if ($urandom_range(0, 99) < noise_pct)
            return 1'($urandom_range(0, 1));
        case (p)
            PH_SB_LOW, PH_HDR_LOW: return 1'b0;
            PH_HDR_BITS, PH_SEND_BITS, PH_READ_BITS:
            begin
                if (b == BIT_SAK)
                    v = slave_sak;
                else if (b == BIT_MAK)
                    v = eng_mak;
                else if (p == PH_READ_BITS)
                    v = slave_byte[7 - b];
                else
                    v = eng_shift[7];
                return (q < 2'd2) ? ~v : v;
            end
            default: return 1'b1;
        endcase
    endfunction

    task automatic send_tick(input logic [2:0] cmd, input logic [7:0] txb, input logic mk,
                             input logic bin);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, bin, mk, txb, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_bus_states.push_back(predict_bus_state(cmd, txb, mk, bin));
        tick_total++;
    endtask

    // issue one command tick, then feed ticks until the engine is idle again
    task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] txb, input logic mk,
                           input int busy_cmd_pct, input int noise_pct);
        logic [2:0] c;
        if (cmd >= CMD_STANDBY && cmd <= CMD_READ)
            cmd_total++;
        send_tick(cmd, txb, mk, slave_level(cmd, noise_pct));
        while (eng_phase != PH_IDLE)
        begin
            c = CMD_NONE;
            if ($urandom_range(0, 99) < busy_cmd_pct)
                c = 3'($urandom_range(1, 7));
            send_tick(c, 8'($urandom), 1'($urandom_range(0, 1)), slave_level(c, noise_pct));
        end
    endtask

    task automatic settle_idle();
        while (eng_phase != PH_IDLE)
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
                      slave_level(CMD_NONE, 0));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bus_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [REG_WIDTH-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QUARTER_BIT: cfg_qbit = val[QBIT_WIDTH-1:0];
            CFG_STANDBY_HIGH: cfg_sb_high = val;
            CFG_SETUP: cfg_setup = val;
            default: cfg_hdr_low = val;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [QBIT_WIDTH-1:0] q, input logic [REG_WIDTH-1:0] sb,
                             input logic [REG_WIDTH-1:0] su, input logic [REG_WIDTH-1:0] hl);
        settle_idle();
        cfg_write(CFG_QUARTER_BIT, {6'd0, q});
        cfg_write(CFG_STANDBY_HIGH, sb);
        cfg_write(CFG_SETUP, su);
        cfg_write(CFG_HEADER_LOW, hl);
    endtask

    task automatic test_reset_defaults();
        slave_sak = 1'b1;
        run_cmd(CMD_GAP, 8'h00, 1'b0, 0, 0);
        // short bit time, header low hold still at its reset value
        settle_idle();
        cfg_write(CFG_QUARTER_BIT, 16'd1);
        run_cmd(CMD_HEADER, 8'h00, 1'b0, 0, 0);
    endtask

    task automatic test_directed_cases();
        configure(10'd1, 16'd1, 16'd1, 16'd1);
        slave_sak = 1'b1;
        run_cmd(CMD_STANDBY, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_GAP, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_SEND, 8'hA5, 1'b1, 0, 0);
        slave_sak = 1'b0;
        run_cmd(CMD_SEND, 8'h00, 1'b0, 0, 0);
        // header ignores a missing SAK
        run_cmd(CMD_HEADER, 8'h00, 1'b0, 0, 0);
        slave_sak = 1'b1;
        slave_byte = 8'h3C;
        run_cmd(CMD_READ, 8'hFF, 1'b1, 0, 0);
        // reserved codes and empty ticks leave the engine idle
        send_tick(CMD_RSVD_6, 8'hFF, 1'b1, 1'b0);
        send_tick(CMD_RSVD_7, 8'h00, 1'b0, 1'b1);
        send_tick(CMD_NONE, 8'h5A, 1'b1, 1'b1);
        // a command on every busy tick, the final one included
        slave_byte = 8'h81;
        run_cmd(CMD_SEND, 8'h3C, 1'b0, 100, 0);
        run_cmd(CMD_READ, 8'h00, 1'b0, 100, 100);
        configure(10'd0, 16'd0, 16'd0, 16'd0);
        run_cmd(CMD_STANDBY, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_GAP, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_HEADER, 8'h00, 1'b0, 0, 0);
        configure(10'd2, 16'd3, 16'd5, 16'd4);
        run_cmd(CMD_STANDBY, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_GAP, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_HEADER, 8'h00, 1'b0, 0, 0);
    endtask

    task automatic test_random_traffic(input int settings, input int tick_budget);
        int s;
        int start;
        int pick;
        logic [2:0] c;
        for (s = 0; s < settings; s++)
        begin
            configure(10'($urandom_range(1, 2)), 16'($urandom_range(1, 20)),
                      16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)));
            start = tick_total;
            while (tick_total - start < tick_budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    c = CMD_READ;
                else if (pick < 60)
                    c = CMD_SEND;
                else if (pick < 75)
                    c = CMD_HEADER;
                else if (pick < 85)
                    c = CMD_GAP;
                else if (pick < 93)
                    c = CMD_STANDBY;
                else
                begin
                    case ($urandom_range(0, 2))
                        0: c = CMD_NONE;
                        1: c = CMD_RSVD_6;
                        default: c = CMD_RSVD_7;
                    endcase
                end
                slave_byte = 8'($urandom);
                slave_sak = ($urandom_range(0, 99) < 80);
                run_cmd(c, 8'($urandom), 1'($urandom_range(0, 1)), 10,
                        ($urandom_range(0, 99) < 10) ? 25 : 0);
                repeat ($urandom_range(0, 2))
                    send_tick(CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_output_backpressure();
        int saved;
        configure(10'd1, 16'd4, 16'd3, 16'd2);
        saved = tx_idle_pct;
        tx_idle_pct = 0;
        hold_cycles = 300;
        slave_byte = 8'h5D;
        slave_sak = 1'b1;
        run_cmd(CMD_READ, 8'h00, 1'b1, 10, 0);
        run_cmd(CMD_SEND, 8'hB7, 1'b0, 10, 0);
        tx_idle_pct = saved;
    endtask

    // upper write-data bits beyond the quarter-bit register width are dropped
    task automatic test_cfg_masking();
        settle_idle();
        cfg_write(CFG_QUARTER_BIT, 16'hFC01);
        slave_sak = 1'b1;
        run_cmd(CMD_SEND, 8'h96, 1'b1, 0, 0);
    endtask

    // result checker and output-side flow control
    initial
    begin
        bus_state_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_bus_states.size() == 0)
                    report_error($sformatf("unexpected result %h", m_axis_tdata));
                else
                begin
                    want = pending_bus_states.pop_front();
                    if (m_axis_tdata[0] !== want.bus_out)
                        report_error($sformatf("bus_out %b, want %b", m_axis_tdata[0],
                                               want.bus_out));
                    if (m_axis_tdata[1] !== want.bus_drive)
                        report_error($sformatf("bus_drive %b, want %b", m_axis_tdata[1],
                                               want.bus_drive));
                    if (m_axis_tdata[2] !== want.busy)
                        report_error($sformatf("busy %b, want %b", m_axis_tdata[2], want.busy));
                    if (m_axis_tdata[3] !== want.done)
                        report_error($sformatf("done %b, want %b", m_axis_tdata[3], want.done));
                    if (m_axis_tdata[11:4] !== want.rx_byte)
                        report_error($sformatf("rx_byte %h, want %h", m_axis_tdata[11:4],
                                               want.rx_byte));
                    if (m_axis_tdata[12] !== want.ack_ok)
                        report_error($sformatf("ack_ok %b, want %b", m_axis_tdata[12],
                                               want.ack_ok));
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int guard;
        eng_phase = PH_IDLE;
        eng_ticks = '0;
        eng_quarter = '0;
        eng_bit = '0;
        eng_shift = '0;
        eng_first = 1'b0;
        eng_mak = 1'b0;
        eng_sak = 1'b0;
        eng_rx = '0;
        cfg_qbit = QBIT_RESET;
        cfg_sb_high = SB_HIGH_RESET;
        cfg_setup = SETUP_RESET;
        cfg_hdr_low = HDR_LOW_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 28;
        rx_idle_pct = 76;
        test_reset_defaults();
        test_directed_cases();
        test_random_traffic(1, 40);

        tx_idle_pct = 76;
        rx_idle_pct = 28;
        test_random_traffic(1, 40);
        test_output_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_cfg_masking();

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_bus_states.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_bus_states.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_bus_states.size()));

        $display("Covered reset values, zero and minimal durations, register masking, all five");
        $display("commands, busy and reserved codes, NoSAK, noise, long stall: %0d ticks, %0d cmds, %0d errors",
                 tick_total, cmd_total, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
